// ===== hw/rtl/lsft_pkg.sv =====
// Shared types and constants of the linear sieve factor table unit.
// No dependencies; all other RTL files but lsft_ram, and the testbench, import this package.
`default_nettype none
package lsft_pkg;

  localparam int TABLE_SIZE  = 65536;
  localparam int PRIME_SLOTS = 8192;
  localparam int TAW         = $clog2(TABLE_SIZE);
  localparam int PAW         = $clog2(PRIME_SLOTS);
  localparam int VAL_W       = 16;
  localparam int CNT_W       = 14;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             command;
    logic [VAL_W-1:0] query_value;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] least_factor;
    logic [VAL_W-1:0] prime_power;
    logic [CNT_W-1:0] primes_found;
    logic [1:0]       status;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic             command;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] limit;
  } core_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lsft_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module lsft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lsft_core.sv =====
// Sieve sequencer: composite map, prime list and the two factor tables in RAM.
// Depends on lsft_pkg and lsft_ram.
`default_nettype none
module lsft_core
  import lsft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  core_req_t req,
  output logic      busy,
  output logic      done,
  output out_word_t res
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_READI = 9'b000000100,
    S_EVALI = 9'b000001000,
    S_READP = 9'b000010000,
    S_MULT  = 9'b000100000,
    S_WRK   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_QRD   = 9'b100000000
  } state_t;

  localparam logic [PAW:0] SLOTS_V = (PAW+1)'(PRIME_SLOTS);

  state_t state_r, state_nxt;
  logic [VAL_W-1:0] lim_r, lim_nxt, built_r, built_nxt;
  logic [VAL_W-1:0] clr_r, clr_nxt, i_r, i_nxt;
  logic [VAL_W-1:0] cur_lf_r, cur_lf_nxt, cur_pw_r, cur_pw_nxt;
  logic [PAW:0]     stored_r, stored_nxt;
  logic [PAW-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, total_r, total_nxt;
  logic             ready_r, ready_nxt;
  logic [2*VAL_W-1:0] k_r;
  logic [VAL_W-1:0] pp_r, p_r;
  logic [2*VAL_W-1:0] k_full, pp_full;

  // RAM ports
  logic           map_we, map_wd, map_q;
  logic [TAW-1:0] map_wa, map_ra;
  logic           lf_we, pw_we;
  logic [TAW-1:0] tab_wa, tab_ra;
  logic [VAL_W-1:0] lf_wd, pw_wd, lf_q, pw_q;
  logic           pl_we;
  logic [PAW-1:0] pl_wa;
  logic [VAL_W-1:0] pl_q;

  lsft_ram #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_map (
    .clk, .we(map_we), .waddr(map_wa), .wdata(map_wd), .raddr(map_ra), .rdata(map_q));
  lsft_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_lf (
    .clk, .we(lf_we), .waddr(tab_wa), .wdata(lf_wd), .raddr(tab_ra), .rdata(lf_q));
  lsft_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_pw (
    .clk, .we(pw_we), .waddr(tab_wa), .wdata(pw_wd), .raddr(tab_ra), .rdata(pw_q));
  lsft_ram #(.WIDTH(VAL_W), .DEPTH(PRIME_SLOTS)) u_plist (
    .clk, .we(pl_we), .waddr(pl_wa), .wdata(i_r), .raddr(j_r), .rdata(pl_q));

  logic is_prime, last_i, k_over, hit;
  assign is_prime = ~map_q;
  assign last_i   = (i_r == lim_r);
  assign k_over   = (k_r > {{VAL_W{1'b0}}, lim_r});
  assign hit      = (p_r == cur_lf_r);
  assign k_full   = {{VAL_W{1'b0}}, pl_q} * {{VAL_W{1'b0}}, i_r};
  assign pp_full  = {{VAL_W{1'b0}}, cur_pw_r} * {{VAL_W{1'b0}}, pl_q};
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    lim_nxt    = lim_r;
    built_nxt  = built_r;
    clr_nxt    = clr_r;
    i_nxt      = i_r;
    cur_lf_nxt = cur_lf_r;
    cur_pw_nxt = cur_pw_r;
    stored_nxt = stored_r;
    j_nxt      = j_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    ready_nxt  = ready_r;
    map_we = 1'b0; map_wd = 1'b0; map_wa = clr_r[TAW-1:0]; map_ra = i_r[TAW-1:0];
    lf_we = 1'b0; pw_we = 1'b0; tab_wa = i_r[TAW-1:0]; tab_ra = i_r[TAW-1:0];
    lf_wd = i_r; pw_wd = i_r;
    pl_we = 1'b0; pl_wa = stored_r[PAW-1:0];
    done = 1'b0;
    res  = '{least_factor: '0, prime_power: '0, primes_found: total_r, status: ST_OK};
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          if (req.command == CMD_BUILD) begin
            lim_nxt    = req.limit;
            clr_nxt    = '0;
            i_nxt      = VAL_W'(2);
            stored_nxt = '0;
            count_nxt  = '0;
            state_nxt  = (req.limit < VAL_W'(2)) ? S_FIN : S_CLEAR;
          end else if (!ready_r) begin
            done = 1'b1;
            res.status = ST_NOT_BUILT;
          end else if (req.value < VAL_W'(2) || req.value > built_r) begin
            done = 1'b1;
            res.status = ST_RANGE;
          end else begin
            tab_ra    = req.value[TAW-1:0];
            state_nxt = S_QRD;
          end
        end
      end
      S_CLEAR: begin
        map_we = 1'b1;
        clr_nxt = clr_r + VAL_W'(1);
        if (clr_r == lim_r) begin
          state_nxt = S_READI;
        end
      end
      S_READI: begin
        state_nxt = S_EVALI;
      end
      S_EVALI: begin
        if (is_prime) begin
          lf_we = 1'b1;
          pw_we = 1'b1;
          cur_lf_nxt = i_r;
          cur_pw_nxt = i_r;
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (stored_r < SLOTS_V) begin
            pl_we = 1'b1;
            stored_nxt = stored_r + (PAW+1)'(1);
          end
        end else begin
          cur_lf_nxt = lf_q;
          cur_pw_nxt = pw_q;
        end
        j_nxt = '0;
        if (stored_nxt != '0) begin
          state_nxt = S_READP;
        end else if (last_i) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt = i_r + VAL_W'(1);
          state_nxt = S_READI;
        end
      end
      S_READP: begin
        state_nxt = S_MULT;
      end
      S_MULT: begin
        state_nxt = S_WRK;
      end
      S_WRK: begin
        if (!k_over) begin
          map_we = 1'b1;
          map_wd = 1'b1;
          map_wa = k_r[TAW-1:0];
          tab_wa = k_r[TAW-1:0];
          lf_we  = 1'b1;
          pw_we  = 1'b1;
          lf_wd  = p_r;
          pw_wd  = hit ? pp_r : p_r;
        end
        if (!k_over && !hit && ({1'b0, j_r} + (PAW+1)'(1)) != stored_r) begin
          j_nxt = j_r + PAW'(1);
          state_nxt = S_READP;
        end else if (last_i) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt = i_r + VAL_W'(1);
          state_nxt = S_READI;
        end
      end
      S_FIN: begin
        total_nxt = count_r;
        built_nxt = lim_r;
        ready_nxt = 1'b1;
        done = 1'b1;
        res.primes_found = count_r;
        state_nxt = S_IDLE;
      end
      S_QRD: begin
        done = 1'b1;
        res.least_factor = lf_q;
        res.prime_power  = pw_q;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      ready_r <= 1'b0;
      built_r <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      ready_r <= ready_nxt;
      built_r <= built_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r    <= lim_nxt;
    clr_r    <= clr_nxt;
    i_r      <= i_nxt;
    cur_lf_r <= cur_lf_nxt;
    cur_pw_r <= cur_pw_nxt;
    stored_r <= stored_nxt;
    j_r      <= j_nxt;
    count_r  <= count_nxt;
    k_r      <= k_full;
    pp_r     <= pp_full[VAL_W-1:0];
    p_r      <= pl_q;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/linear_sieve_factor_table_unit.sv =====
// Top level of the linear sieve factor table unit: handshakes, limit register,
// output register. Depends on lsft_pkg and lsft_core.
//
//   Channel  Direction  Handshake             Word
//   in_      input      in_valid / in_stall   in_word_t (command, query_value)
//   out_     output     out_valid / out_stall out_word_t (factor, power, count, status)
//   cfg_     input      cfg_wr_en             16-bit sieve limit
//
// A query that passes the build and range checks reads both tables, and
// its result word is registered from the query read state; a query that
// fails a check is answered from the idle state. A build clears the
// composite map from entry 0 up to the limit, then reads and evaluates each
// value, and reads, multiplies and writes for each prime tried against it,
// and ends in a closing state; a limit below two goes straight to the closing
// state. Reset is synchronous and active low; it clears the built flag and
// prime count, while table RAMs keep their contents.
// The input is stalled while the core works or a result word waits in the
// output register.
`default_nettype none
module linear_sieve_factor_table_unit
  import lsft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data
);

  logic [VAL_W-1:0] limit_r;
  logic             out_valid_r;
  out_word_t        out_data_r;
  core_req_t        req;
  logic             busy, done;
  out_word_t        res;

  // A new word enters only when the core is idle and no result is pending.
  assign in_stall = busy | out_valid_r;

  assign req = '{start: in_valid & ~in_stall, command: in_data.command,
                 value: in_data.query_value, limit: limit_r};

  lsft_core u_core (
    .clk, .rst_n, .req, .busy, .done, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= {VAL_W{1'b1}};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The core only finishes while the output register is empty.
  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lsft_checker.sv =====
// Port-level checks for the linear sieve factor table unit, bound to the top.
// Depends on lsft_pkg.
`default_nettype none
module lsft_checker
  import lsft_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result word dropped");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.least_factor == '0 && out_data.prime_power == '0)
    else $error("error word carries factors");

endmodule

bind linear_sieve_factor_table_unit lsft_checker u_lsft_checker (.*);
`default_nettype wire

// ===== tb/linear_sieve_factor_table_unit_tb.sv =====
// Self-checking testbench for the linear sieve factor table unit: builds and
// queries under several sieve limits, random idling and a long output hold-off.
// Depends on lsft_pkg and the linear_sieve_factor_table_unit RTL.
`default_nettype none
module linear_sieve_factor_table_unit_tb;
  import lsft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 6000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [VAL_W-1:0] cfg_wr_data = '0;

  linear_sieve_factor_table_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Our own picture of the block: sieve tables, prime list, count and limits.
  bit               composite_seen [TABLE_SIZE];
  int unsigned      prime_store    [PRIME_SLOTS];
  logic [VAL_W-1:0] factor_tab     [TABLE_SIZE];
  logic [VAL_W-1:0] power_tab      [TABLE_SIZE];
  logic [CNT_W-1:0] prime_count_q  = '0;
  bit               table_built    = 1'b0;
  logic [VAL_W-1:0] limit_reg      = 16'hFFFF;
  int unsigned      built_limit    = 0;

  out_word_t   expected_words[$];
  int unsigned fail_count = 0;
  int unsigned words_checked = 0;
  int unsigned words_sent = 0;
  int unsigned builds_sent = 0;
  int unsigned cycle_count = 0;

  // Idle percentages of both sides, and the long hold-off of the receiver.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  // Linear sieve over 2..limit: each composite is struck once, by its smallest
  // prime factor, and the power of that factor is carried from the cofactor.
  task automatic sieve_build();
    int unsigned lim, stored, count, i, j, p, k;
    lim = limit_reg;
    stored = 0;
    count = 0;
    for (i = 0; i < TABLE_SIZE; i++) composite_seen[i] = 1'b0;
    for (i = 2; i <= lim; i++) begin
      if (!composite_seen[i]) begin
        if (stored < PRIME_SLOTS) begin
          prime_store[stored] = i;
          stored++;
        end
        if (count < COUNT_MAX) count++;
        factor_tab[i] = i[VAL_W-1:0];
        power_tab[i] = i[VAL_W-1:0];
      end
      for (j = 0; j < stored; j++) begin
        p = prime_store[j];
        k = p * i;
        if (k > lim) break;
        composite_seen[k] = 1'b1;
        factor_tab[k] = p[VAL_W-1:0];
        if (factor_tab[i] == p[VAL_W-1:0]) begin
          power_tab[k] = VAL_W'(power_tab[i] * p);
          break;
        end
        power_tab[k] = p[VAL_W-1:0];
      end
    end
    prime_count_q = count[CNT_W-1:0];
    built_limit = lim;
    table_built = 1'b1;
  endtask

  // Expected result word for one accepted command word.
  task automatic predict_word(input in_word_t w);
    out_word_t r;
    r = '0;
    if (w.command == CMD_BUILD) begin
      sieve_build();
      r.status = ST_OK;
    end else if (!table_built) begin
      r.status = ST_NOT_BUILT;
    end else if (w.query_value < 2 || w.query_value > built_limit) begin
      r.status = ST_RANGE;
    end else begin
      r.least_factor = factor_tab[w.query_value];
      r.prime_power = power_tab[w.query_value];
      r.status = ST_OK;
    end
    r.primes_found = prime_count_q;
    expected_words.push_back(r);
  endtask

  // Offer one word; valid stays high between back-to-back words.
  task automatic send_word(input logic cmd, input logic [VAL_W-1:0] value);
    in_word_t w;
    w.command = cmd;
    w.query_value = value;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    words_sent++;
    if (cmd == CMD_BUILD) builds_sent++;
  endtask

  // Lower valid and wait until every expected word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The limit register is only written while the block is idle.
  task automatic write_limit(input logic [VAL_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
  endtask

  task automatic test_query_before_build();
    send_word(CMD_QUERY, 16'd0);
    send_word(CMD_QUERY, 16'd1);
    send_word(CMD_QUERY, 16'd2);
    send_word(CMD_QUERY, 16'hFFFF);
  endtask

  // Limits below two find no primes, so every query is out of range; a limit of two finds the prime two.
  task automatic test_tiny_limits();
    write_limit(16'd0);
    send_word(CMD_BUILD, 16'hFFFF);
    send_word(CMD_QUERY, 16'd0);
    send_word(CMD_QUERY, 16'd2);
    write_limit(16'd1);
    send_word(CMD_BUILD, 16'd0);
    send_word(CMD_QUERY, 16'd1);
    write_limit(16'd2);
    send_word(CMD_BUILD, 16'd0);
    send_word(CMD_QUERY, 16'd2);
    send_word(CMD_QUERY, 16'd3);
  endtask

  // Queries keep using the limit of the last build after the register moves.
  task automatic test_limit_change_after_build();
    write_limit(16'd100);
    send_word(CMD_BUILD, 16'd0);
    send_word(CMD_QUERY, 16'd64);
    send_word(CMD_QUERY, 16'd97);
    send_word(CMD_QUERY, 16'd100);
    send_word(CMD_QUERY, 16'd101);
    write_limit(16'd50);
    send_word(CMD_QUERY, 16'd96);
    send_word(CMD_QUERY, 16'd51);
  endtask

  // The output is held off for a long stretch while queries keep coming, so
  // the block fills and stalls its input; then the sender waits for a drain.
  task automatic test_output_hold_off();
    int n;
    write_limit(16'd300);
    send_word(CMD_BUILD, 16'd0);
    drain_results();
    hold_request = 400;
    for (n = 0; n < 40; n++) send_word(CMD_QUERY, 16'($urandom_range(2, 300)));
    drain_results();
  endtask

  // Random rounds: set a limit, build, then mostly in-range queries with some
  // out-of-range ones and occasional stale queries after a limit change.
  task automatic test_random_rounds(input int unsigned tx_pct, input int unsigned rx_pct,
                                    input int unsigned item_goal);
    int unsigned goal, lim, n, q, r;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = words_sent + item_goal;
    while (words_sent < goal) begin
      r = $urandom_range(99);
      if (r < 4) lim = $urandom_range(0, 1);
      else if (r < 14) lim = $urandom_range(600, 3000);
      else lim = $urandom_range(2, 600);
      write_limit(16'(lim));
      if ($urandom_range(9) == 0) begin
        // A stale query against the previous build.
        send_word(CMD_QUERY, 16'($urandom));
      end
      send_word(CMD_BUILD, 16'($urandom));
      n = $urandom_range(15, 40);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 85 && built_limit >= 2) q = $urandom_range(2, built_limit);
        else if (r < 93) q = $urandom_range(0, 65535);
        else q = $urandom_range(0, 1);
        send_word(CMD_QUERY, 16'(q));
      end
    end
    drain_results();
  endtask

  // One build at the full limit, with the largest values and high powers.
  task automatic test_full_limit();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_limit(16'hFFFF);
    send_word(CMD_BUILD, 16'd0);
    send_word(CMD_QUERY, 16'hFFFF);
    send_word(CMD_QUERY, 16'd65521);
    send_word(CMD_QUERY, 16'd32768);
    send_word(CMD_QUERY, 16'd59049);
    send_word(CMD_QUERY, 16'd65534);
    repeat (30) send_word(CMD_QUERY, 16'($urandom));
    drain_results();
  endtask

  // Receiver: random stalls, or a long hold-off counted here.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Each accepted result word is compared with the oldest expected word.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", out_data);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        words_checked++;
        if (out_data.least_factor !== e.least_factor) begin
          $error("least_factor expected %0d actual %0d", e.least_factor,
                 out_data.least_factor);
          fail_count++;
        end
        if (out_data.prime_power !== e.prime_power) begin
          $error("prime_power expected %0d actual %0d", e.prime_power,
                 out_data.prime_power);
          fail_count++;
        end
        if (out_data.primes_found !== e.primes_found) begin
          $error("primes_found expected %0d actual %0d", e.primes_found,
                 out_data.primes_found);
          fail_count++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    test_query_before_build();
    test_tiny_limits();
    test_limit_change_after_build();
    test_output_hold_off();
    test_random_rounds(26, 62, 390);
    test_random_rounds(62, 26, 390);
    test_random_rounds(0, 0, 390);
    test_full_limit();
    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      fail_count++;
    end
    $display("Sent %0d words (%0d builds), checked %0d results, limits 0..65535.",
             words_sent, builds_sent, words_checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/lsft_pkg.sv
hw/rtl/lsft_ram.sv
hw/rtl/lsft_core.sv
hw/rtl/linear_sieve_factor_table_unit.sv
hw/rtl/lsft_checker.sv
tb/linear_sieve_factor_table_unit_tb.sv
